// File: hw/rtl/bine_pkg.sv
// shared types and constants for the b+ tree internal node engine
// no dependencies
package bine_pkg;

  localparam int KEY_SLOTS = 255;
  localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
  localparam int IDX_W     = CNT_W + 1;
  localparam int KEY_AW    = $clog2(KEY_SLOTS);
  localparam int CH_AW     = $clog2(KEY_SLOTS + 1);
  localparam logic [11:0] THR_RESET = 12'd2048;

  typedef enum logic [2:0] {
    K_INIT = 3'd0, K_LOOKUP = 3'd1, K_INSERT = 3'd2, K_LEFT = 3'd3,
    K_RIGHT = 3'd4, K_SETKEY = 3'd5, K_DELETE = 3'd6, K_LEND = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_NO_LEFT = 3'd2,
    ST_NO_RIGHT = 3'd3, ST_FULL = 3'd4
  } st_code_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_STATUS, OP_LEND, OP_RD_KEY, OP_RD_CHILD,
    OP_IDX_INC, OP_RD_NBR_L, OP_RD_NBR_R, OP_TAKE_CHILD, OP_INS_START,
    OP_INS_RD, OP_INS_WR, OP_INS_PUT, OP_SET_KEY, OP_DEL_TAKE, OP_DEL_RD,
    OP_DEL_WR, OP_DEL_END, OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_CH_RD, S_CH_TAKE,
    S_INS_CHK, S_INS_WR, S_FIND_RD, S_FIND_CMP, S_DEL_TAKE, S_DEL_CHK,
    S_DEL_WR, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t   op;
    st_code_t st;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  idx_lt_held;
    logic  idx_gt_held;
    logic  idx_eq_held;
    logic  idx_zero;
    logic  idx_gt_pos;
    logic  del_more;
    logic  key_le;
    logic  child_eq;
    logic  full;
    logic  out_busy;
  } flags_t;

endpackage

// File: hw/rtl/bine_if.sv
// handshake channel interfaces for the node engine
// depends on nothing
interface bine_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] key;
  logic [63:0] child_id;
  logic [11:0] needed_bytes;
  modport source (output valid, kind, key, child_id, needed_bytes, input ready);
  modport sink (input valid, kind, key, child_id, needed_bytes, output ready);
endinterface

interface bine_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] child_out;
  logic [63:0] key_out;
  logic [7:0]  key_count;
  logic        has_room;
  logic [12:0] used_bytes;
  logic        underflow;
  logic        can_lend;
  logic [7:0]  lend_pairs;
  modport source (output valid, status, child_out, key_out, key_count, has_room,
                  used_bytes, underflow, can_lend, lend_pairs, input ready);
  modport sink (input valid, status, child_out, key_out, key_count, has_room,
                used_bytes, underflow, can_lend, lend_pairs, output ready);
endinterface

interface bine_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/bine_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module bine_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: hw/rtl/bine_ctrl.sv
// sequencer for the node engine: walks scans and shifts step by step
// depends on bine_pkg
module bine_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bine_pkg::flags_t flg,
  output bine_pkg::cmd_t  cmd
);
  bine_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bine_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic is_lookup;
  assign is_lookup = (flg.kind == bine_pkg::K_LOOKUP);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bine_pkg::S_IDLE: if (in_valid) state_nxt = bine_pkg::S_DISPATCH;
      bine_pkg::S_DISPATCH: begin
        case (flg.kind)
          bine_pkg::K_LOOKUP: state_nxt = bine_pkg::S_SCAN_RD;
          bine_pkg::K_INSERT:
            state_nxt = flg.full ? bine_pkg::S_DONE : bine_pkg::S_SCAN_RD;
          bine_pkg::K_LEFT, bine_pkg::K_RIGHT, bine_pkg::K_SETKEY,
          bine_pkg::K_DELETE: state_nxt = bine_pkg::S_FIND_RD;
          default: state_nxt = bine_pkg::S_DONE;
        endcase
      end
      bine_pkg::S_SCAN_RD: begin
        if (flg.idx_lt_held) state_nxt = bine_pkg::S_SCAN_CMP;
        else state_nxt = is_lookup ? bine_pkg::S_CH_RD : bine_pkg::S_INS_CHK;
      end
      bine_pkg::S_SCAN_CMP: begin
        if (flg.key_le) state_nxt = bine_pkg::S_SCAN_RD;
        else state_nxt = is_lookup ? bine_pkg::S_CH_RD : bine_pkg::S_INS_CHK;
      end
      bine_pkg::S_CH_RD: state_nxt = bine_pkg::S_CH_TAKE;
      bine_pkg::S_CH_TAKE: state_nxt = bine_pkg::S_DONE;
      bine_pkg::S_INS_CHK:
        state_nxt = flg.idx_gt_pos ? bine_pkg::S_INS_WR : bine_pkg::S_DONE;
      bine_pkg::S_INS_WR: state_nxt = bine_pkg::S_INS_CHK;
      bine_pkg::S_FIND_RD:
        state_nxt = flg.idx_gt_held ? bine_pkg::S_DONE : bine_pkg::S_FIND_CMP;
      bine_pkg::S_FIND_CMP: begin
        if (!flg.child_eq) begin
          state_nxt = bine_pkg::S_FIND_RD;
        end else begin
          case (flg.kind)
            bine_pkg::K_LEFT:
              state_nxt = flg.idx_zero ? bine_pkg::S_DONE : bine_pkg::S_CH_TAKE;
            bine_pkg::K_RIGHT:
              state_nxt = flg.idx_eq_held ? bine_pkg::S_DONE : bine_pkg::S_CH_TAKE;
            bine_pkg::K_DELETE:
              state_nxt = flg.idx_eq_held ? bine_pkg::S_DONE : bine_pkg::S_DEL_TAKE;
            default: state_nxt = bine_pkg::S_DONE;
          endcase
        end
      end
      bine_pkg::S_DEL_TAKE: state_nxt = bine_pkg::S_DEL_CHK;
      bine_pkg::S_DEL_CHK:
        state_nxt = flg.del_more ? bine_pkg::S_DEL_WR : bine_pkg::S_DONE;
      bine_pkg::S_DEL_WR: state_nxt = bine_pkg::S_DEL_CHK;
      bine_pkg::S_DONE: if (!flg.out_busy) state_nxt = bine_pkg::S_IDLE;
      default: state_nxt = bine_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = bine_pkg::OP_NONE;
    cmd.st   = bine_pkg::ST_OK;
    in_ready = 1'b0;
    case (state_r)
      bine_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = bine_pkg::OP_LOAD;
      end
      bine_pkg::S_DISPATCH: begin
        case (flg.kind)
          bine_pkg::K_INIT: cmd.op = bine_pkg::OP_INIT;
          bine_pkg::K_INSERT: begin
            if (flg.full) begin
              cmd.op = bine_pkg::OP_STATUS;
              cmd.st = bine_pkg::ST_FULL;
            end
          end
          bine_pkg::K_LEND: cmd.op = bine_pkg::OP_LEND;
          default: cmd.op = bine_pkg::OP_NONE;
        endcase
      end
      bine_pkg::S_SCAN_RD: begin
        if (flg.idx_lt_held) cmd.op = bine_pkg::OP_RD_KEY;
        else if (!is_lookup) cmd.op = bine_pkg::OP_INS_START;
      end
      bine_pkg::S_SCAN_CMP: begin
        if (flg.key_le) cmd.op = bine_pkg::OP_IDX_INC;
        else if (!is_lookup) cmd.op = bine_pkg::OP_INS_START;
      end
      bine_pkg::S_CH_RD: cmd.op = bine_pkg::OP_RD_CHILD;
      bine_pkg::S_CH_TAKE: cmd.op = bine_pkg::OP_TAKE_CHILD;
      bine_pkg::S_INS_CHK:
        cmd.op = flg.idx_gt_pos ? bine_pkg::OP_INS_RD : bine_pkg::OP_INS_PUT;
      bine_pkg::S_INS_WR: cmd.op = bine_pkg::OP_INS_WR;
      bine_pkg::S_FIND_RD: begin
        if (flg.idx_gt_held) begin
          cmd.op = bine_pkg::OP_STATUS;
          cmd.st = bine_pkg::ST_NOT_FOUND;
        end else begin
          cmd.op = bine_pkg::OP_RD_CHILD;
        end
      end
      bine_pkg::S_FIND_CMP: begin
        if (!flg.child_eq) begin
          cmd.op = bine_pkg::OP_IDX_INC;
        end else if (flg.kind == bine_pkg::K_LEFT) begin
          if (flg.idx_zero) begin
            cmd.op = bine_pkg::OP_STATUS;
            cmd.st = bine_pkg::ST_NO_LEFT;
          end else begin
            cmd.op = bine_pkg::OP_RD_NBR_L;
          end
        end else if (flg.idx_eq_held) begin
          cmd.op = bine_pkg::OP_STATUS;
          cmd.st = bine_pkg::ST_NO_RIGHT;
        end else begin
          case (flg.kind)
            bine_pkg::K_RIGHT: cmd.op = bine_pkg::OP_RD_NBR_R;
            bine_pkg::K_SETKEY: cmd.op = bine_pkg::OP_SET_KEY;
            default: cmd.op = bine_pkg::OP_RD_KEY;
          endcase
        end
      end
      bine_pkg::S_DEL_TAKE: cmd.op = bine_pkg::OP_DEL_TAKE;
      bine_pkg::S_DEL_CHK:
        cmd.op = flg.del_more ? bine_pkg::OP_DEL_RD : bine_pkg::OP_DEL_END;
      bine_pkg::S_DEL_WR: cmd.op = bine_pkg::OP_DEL_WR;
      bine_pkg::S_DONE: if (!flg.out_busy) cmd.op = bine_pkg::OP_FINISH;
      default: cmd.op = bine_pkg::OP_NONE;
    endcase
  end
endmodule

// File: hw/rtl/bine_dp.sv
// datapath: key and child rams, index counter, result and output registers
// depends on bine_pkg and bine_ram
module bine_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  bine_pkg::cmd_t   cmd,
  output bine_pkg::flags_t flg,
  input  logic [2:0]       in_kind,
  input  logic [63:0]      in_key,
  input  logic [63:0]      in_child_id,
  input  logic [11:0]      in_needed,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [63:0]      out_child_out,
  output logic [63:0]      out_key_out,
  output logic [7:0]       out_key_count,
  output logic             out_has_room,
  output logic [12:0]      out_used_bytes,
  output logic             out_underflow,
  output logic             out_can_lend,
  output logic [7:0]       out_lend_pairs
);
  localparam int IW = bine_pkg::IDX_W;

  bine_pkg::kind_t    kind_r;
  logic [63:0]        key_r, cid_r;
  logic [11:0]        needed_r;
  logic [11:0]        thr_r;
  logic [IW-1:0]      idx_r, idx_nxt, pos_r;
  logic [bine_pkg::CNT_W-1:0] held_r;
  bine_pkg::st_code_t st_r;
  logic [63:0]        cout_r, kout_r;
  logic               lend_r;
  logic [7:0]         pairs_r;
  logic               ov_r;

  // ram ports
  logic               kwe, cwe;
  logic [IW-1:0]      kwa, kra, cwa, cra;
  logic [63:0]        kwd, cwd, krd, crd;

  logic [IW-1:0] held_x;
  assign held_x = IW'(held_r);

  logic [12:0] used;
  assign used = {held_r, 4'b0} + 13'd8;

  // lend arithmetic
  logic [12:0] need_up;
  logic [8:0]  pairs;
  logic [12:0] loss;
  logic        can_lend;
  logic [11:0] in_needed_sel;
  assign in_needed_sel = needed_r;
  assign need_up  = 13'(in_needed_sel) + 13'd15;
  assign pairs    = need_up[12:4];
  assign loss     = {pairs, 4'b0};
  assign can_lend = (used >= loss) && ((used - loss) > 13'(thr_r));

  always_comb begin
    kwe = 1'b0; cwe = 1'b0;
    kwa = idx_r; cwa = idx_r; kra = idx_r; cra = idx_r;
    kwd = krd; cwd = crd;
    idx_nxt = idx_r;
    case (cmd.op)
      bine_pkg::OP_LOAD: idx_nxt = '0;
      bine_pkg::OP_INIT: begin
        cwe = 1'b1; cwa = '0; cwd = cid_r;
      end
      bine_pkg::OP_IDX_INC: idx_nxt = idx_r + 1'b1;
      bine_pkg::OP_RD_NBR_L: cra = idx_r - 1'b1;
      bine_pkg::OP_RD_NBR_R: cra = idx_r + 1'b1;
      bine_pkg::OP_INS_START: idx_nxt = held_x;
      bine_pkg::OP_INS_RD: kra = idx_r - 1'b1;
      bine_pkg::OP_INS_WR: begin
        kwe = 1'b1; cwe = 1'b1; cwa = idx_r + 1'b1;
        idx_nxt = idx_r - 1'b1;
      end
      bine_pkg::OP_INS_PUT: begin
        kwe = 1'b1; kwa = pos_r; kwd = key_r;
        cwe = 1'b1; cwa = pos_r + 1'b1; cwd = cid_r;
      end
      bine_pkg::OP_SET_KEY: begin
        kwe = 1'b1; kwd = key_r;
      end
      bine_pkg::OP_DEL_RD: begin
        kra = idx_r + 1'b1; cra = idx_r + IW'(2);
      end
      bine_pkg::OP_DEL_WR: begin
        kwe = 1'b1; cwe = 1'b1; cwa = idx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      default: idx_nxt = idx_r;
    endcase
  end

  bine_ram #(.WIDTH(64), .DEPTH(bine_pkg::KEY_SLOTS)) u_keys (
    .clk(clk), .we(kwe), .waddr(kwa[bine_pkg::KEY_AW-1:0]), .wdata(kwd),
    .raddr(kra[bine_pkg::KEY_AW-1:0]), .rdata(krd)
  );

  bine_ram #(.WIDTH(64), .DEPTH(bine_pkg::KEY_SLOTS + 1)) u_children (
    .clk(clk), .we(cwe), .waddr(cwa[bine_pkg::CH_AW-1:0]), .wdata(cwd),
    .raddr(cra[bine_pkg::CH_AW-1:0]), .rdata(crd)
  );

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    case (cmd.op)
      bine_pkg::OP_LOAD: begin
        kind_r   <= bine_pkg::kind_t'(in_kind);
        key_r    <= in_key;
        cid_r    <= in_child_id;
        needed_r <= in_needed;
        st_r     <= bine_pkg::ST_OK;
        cout_r   <= '0;
        kout_r   <= '0;
        lend_r   <= 1'b0;
        pairs_r  <= '0;
      end
      bine_pkg::OP_STATUS: st_r <= cmd.st;
      bine_pkg::OP_LEND: begin
        lend_r  <= can_lend;
        pairs_r <= !can_lend ? 8'd0 : (pairs[8] ? 8'hFF : pairs[7:0]);
      end
      bine_pkg::OP_TAKE_CHILD: cout_r <= crd;
      bine_pkg::OP_INS_START: pos_r <= idx_r;
      bine_pkg::OP_DEL_TAKE: kout_r <= krd;
      default: pos_r <= pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      thr_r  <= bine_pkg::THR_RESET;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      case (cmd.op)
        bine_pkg::OP_INIT: held_r <= '0;
        bine_pkg::OP_INS_PUT: held_r <= held_r + 1'b1;
        bine_pkg::OP_DEL_END: held_r <= held_r - 1'b1;
        default: held_r <= held_r;
      endcase
      if (cmd.op == bine_pkg::OP_FINISH) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bine_pkg::OP_FINISH) begin
      out_status     <= st_r;
      out_child_out  <= cout_r;
      out_key_out    <= kout_r;
      out_key_count  <= 8'(held_r);
      out_has_room   <= (32'(held_r) < bine_pkg::KEY_SLOTS);
      out_used_bytes <= used;
      out_underflow  <= (used <= 13'(thr_r));
      out_can_lend   <= lend_r;
      out_lend_pairs <= pairs_r;
    end
  end

  assign out_valid = ov_r;

  assign flg.kind        = kind_r;
  assign flg.idx_lt_held = idx_r < held_x;
  assign flg.idx_gt_held = idx_r > held_x;
  assign flg.idx_eq_held = idx_r == held_x;
  assign flg.idx_zero    = idx_r == '0;
  assign flg.idx_gt_pos  = idx_r > pos_r;
  assign flg.del_more    = (idx_r + 1'b1) < held_x;
  assign flg.key_le      = krd <= key_r;
  assign flg.child_eq    = crd == cid_r;
  assign flg.full        = 32'(held_r) >= bine_pkg::KEY_SLOTS;
  assign flg.out_busy    = ov_r && !out_ready;
endmodule

// File: hw/rtl/btree_internal_node_engine.sv
// init and lend query answer straight from dispatch; lookup, insert, sibling, set boundary
// and delete walk the key and child rams entry by entry in a scan and shift loop;
// one item in flight, a new beat is taken while a result waits
// reset clears the key count, the output valid and sets the threshold to 2048;
// node contents stay undefined until the first init
module btree_internal_node_engine (
  input logic         clk,
  input logic         rst_n,
  bine_req_if.sink    in_req,
  bine_rsp_if.source  out_rsp,
  bine_cfg_if.sink    cfg_wr
);
  bine_pkg::cmd_t   cmd;
  bine_pkg::flags_t flg;

  assign cfg_wr.ready = 1'b1;

  bine_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
    .flg(flg), .cmd(cmd)
  );

  bine_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .flg(flg),
    .in_kind(in_req.kind), .in_key(in_req.key), .in_child_id(in_req.child_id),
    .in_needed(in_req.needed_bytes),
    .cfg_we(cfg_wr.valid), .cfg_data(cfg_wr.data),
    .out_ready(out_rsp.ready), .out_valid(out_rsp.valid),
    .out_status(out_rsp.status), .out_child_out(out_rsp.child_out),
    .out_key_out(out_rsp.key_out), .out_key_count(out_rsp.key_count),
    .out_has_room(out_rsp.has_room), .out_used_bytes(out_rsp.used_bytes),
    .out_underflow(out_rsp.underflow), .out_can_lend(out_rsp.can_lend),
    .out_lend_pairs(out_rsp.lend_pairs)
  );
endmodule

// File: bench/btree_internal_node_engine_tb.sv
// self-checking bench for the b+ tree internal node engine
// depends on bine_pkg, the bine_*_if interfaces and btree_internal_node_engine
module btree_internal_node_engine_tb;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] child_out;
    logic [63:0] key_out;
    logic [7:0]  key_count;
    logic        has_room;
    logic [12:0] used_bytes;
    logic        underflow;
    logic        can_lend;
    logic [7:0]  lend_pairs;
  } node_rsp_t;

  typedef struct {
    bine_pkg::kind_t    kind;
    logic [63:0]        key;
    logic [63:0]        cid;
    logic [11:0]        need;
    bit                 typed;
    bine_pkg::st_code_t st;
    logic [63:0]        child;
    logic [7:0]         cnt;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  bine_req_if req ();
  bine_rsp_if rsp ();
  bine_cfg_if cfg ();

  btree_internal_node_engine u_top (
    .clk(clk), .rst_n(rst_n), .in_req(req), .out_rsp(rsp), .cfg_wr(cfg)
  );

  // shadow node
  logic [63:0] nd_keys[bine_pkg::KEY_SLOTS];
  logic [63:0] nd_children[bine_pkg::KEY_SLOTS+1];
  int unsigned nd_count;
  logic [11:0] nd_thr;

  node_rsp_t   pending_rsp_q[$];
  int          err_count;
  int          beats_in, beats_out, full_hits, lend_yes;
  int          kind_seen[8];
  int unsigned cycle_count;
  bit          quiet;
  int          long_hold;
  // typed expectation for the directed row being sent
  bit          row_typed;
  dir_row_t    row_now;

  function automatic int unsigned upper_pos(logic [63:0] k);
    int unsigned i;
    i = 0;
    while (i < nd_count && nd_keys[i] <= k) i++;
    return i;
  endfunction

  function automatic int unsigned find_child(logic [63:0] id);
    for (int unsigned j = 0; j <= nd_count; j++)
      if (nd_children[j] == id) return j;
    return nd_count + 1;
  endfunction

  function automatic node_rsp_t predict_node(logic [2:0] kind_raw, logic [63:0] key,
                                             logic [63:0] cid, logic [11:0] need);
    node_rsp_t       r;
    bine_pkg::kind_t kind;
    int unsigned     i, j, used, pairs, loss;
    r = '0;
    kind = bine_pkg::kind_t'(kind_raw);
    case (kind)
      bine_pkg::K_INIT: begin
        nd_children[0] = cid;
        nd_count = 0;
      end
      bine_pkg::K_LOOKUP: r.child_out = nd_children[upper_pos(key)];
      bine_pkg::K_INSERT: begin
        if (nd_count >= bine_pkg::KEY_SLOTS) begin
          r.status = bine_pkg::ST_FULL;
          full_hits++;
        end else begin
          i = upper_pos(key);
          for (j = nd_count; j > i; j--) nd_keys[j] = nd_keys[j-1];
          nd_keys[i] = key;
          for (j = nd_count + 1; j > i + 1; j--) nd_children[j] = nd_children[j-1];
          nd_children[i+1] = cid;
          nd_count++;
        end
      end
      bine_pkg::K_LEFT, bine_pkg::K_RIGHT: begin
        j = find_child(cid);
        if (j > nd_count) r.status = bine_pkg::ST_NOT_FOUND;
        else if (kind == bine_pkg::K_LEFT && j == 0) r.status = bine_pkg::ST_NO_LEFT;
        else if (kind == bine_pkg::K_RIGHT && j == nd_count)
          r.status = bine_pkg::ST_NO_RIGHT;
        else r.child_out = (kind == bine_pkg::K_LEFT) ? nd_children[j-1] : nd_children[j+1];
      end
      bine_pkg::K_SETKEY, bine_pkg::K_DELETE: begin
        j = find_child(cid);
        if (j > nd_count) r.status = bine_pkg::ST_NOT_FOUND;
        else if (j == nd_count) r.status = bine_pkg::ST_NO_RIGHT;
        else if (kind == bine_pkg::K_SETKEY) nd_keys[j] = key;
        else begin
          r.key_out = nd_keys[j];
          for (i = j; i + 1 < nd_count; i++) nd_keys[i] = nd_keys[i+1];
          for (i = j + 1; i < nd_count; i++) nd_children[i] = nd_children[i+1];
          nd_count--;
        end
      end
      default: begin
        pairs = (need + 15) / 16;
        loss = pairs * 16;
        used = nd_count * 16 + 8;
        // a loss larger than the bytes held means nothing can be lent
        if (used >= loss && used - loss > nd_thr) begin
          r.can_lend = 1'b1;
          r.lend_pairs = (pairs > 255) ? 8'd255 : pairs[7:0];
          lend_yes++;
        end
      end
    endcase
    used = nd_count * 16 + 8;
    r.key_count  = nd_count[7:0];
    r.has_room   = nd_count < bine_pkg::KEY_SLOTS;
    r.used_bytes = used[12:0];
    r.underflow  = used <= nd_thr;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at beat %0d: %s got 0x%0h want 0x%0h", beats_out, field, got, want);
    err_count++;
  endtask

  // prediction on accepted input beats, checking on accepted result beats
  always @(posedge clk) begin
    node_rsp_t e;
    if (rst_n && req.valid && req.ready) begin
      e = predict_node(req.kind, req.key, req.child_id, req.needed_bytes);
      if (row_typed) begin
        e.status = row_now.st;
        e.child_out = row_now.child;
        e.key_count = row_now.cnt;
      end
      pending_rsp_q.push_back(e);
      kind_seen[req.kind]++;
      beats_in++;
    end
    if (rst_n && rsp.valid && rsp.ready) begin
      beats_out++;
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'd1, 64'd0);
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp.status !== e.status)
          report_mismatch("status", 64'(rsp.status), 64'(e.status));
        if (rsp.child_out !== e.child_out)
          report_mismatch("child_out", rsp.child_out, e.child_out);
        if (rsp.key_out !== e.key_out) report_mismatch("key_out", rsp.key_out, e.key_out);
        if (rsp.key_count !== e.key_count)
          report_mismatch("key_count", 64'(rsp.key_count), 64'(e.key_count));
        if (rsp.has_room !== e.has_room)
          report_mismatch("has_room", 64'(rsp.has_room), 64'(e.has_room));
        if (rsp.used_bytes !== e.used_bytes)
          report_mismatch("used_bytes", 64'(rsp.used_bytes), 64'(e.used_bytes));
        if (rsp.underflow !== e.underflow)
          report_mismatch("underflow", 64'(rsp.underflow), 64'(e.underflow));
        if (rsp.can_lend !== e.can_lend)
          report_mismatch("can_lend", 64'(rsp.can_lend), 64'(e.can_lend));
        if (rsp.lend_pairs !== e.lend_pairs)
          report_mismatch("lend_pairs", 64'(rsp.lend_pairs), 64'(e.lend_pairs));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rsp_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random hold-offs, plus a long one on request
  initial begin
    int w;
    rsp.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        w = long_hold;
        long_hold = 0;
      end else w = quiet ? 0 : $urandom_range(0, 17);
      rsp.ready = 0;
      repeat (w) @(negedge clk);
      rsp.ready = 1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  task automatic send_item(bine_pkg::kind_t kind, logic [63:0] key, logic [63:0] cid,
                           logic [11:0] need);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      req.valid = 0;
      @(negedge clk);
    end
    req.valid = 1;
    req.kind = kind;
    req.key = key;
    req.child_id = cid;
    req.needed_bytes = need;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 0;
  endtask

  task automatic drain();
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [11:0] thr);
    drain();
    cfg.valid = 1;
    cfg.data = thr;
    do @(posedge clk); while (!cfg.ready);
    nd_thr = thr;
    @(negedge clk);
    cfg.valid = 0;
  endtask

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  // mostly children that are in the node, sometimes strangers
  function automatic logic [63:0] rand_child();
    if ($urandom_range(0, 4) != 0) return nd_children[$urandom_range(0, nd_count)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_item(int cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4 || nd_count > cap)
      send_item(bine_pkg::K_INIT, rand_key(), {$urandom, $urandom}, 12'($urandom));
    else if (r < 34)
      send_item(bine_pkg::K_INSERT, rand_key(), {$urandom, $urandom}, 12'($urandom));
    else if (r < 52) send_item(bine_pkg::K_LOOKUP, rand_key(), rand_child(), 12'($urandom));
    else if (r < 60) send_item(bine_pkg::K_LEFT, rand_key(), rand_child(), 12'($urandom));
    else if (r < 68) send_item(bine_pkg::K_RIGHT, rand_key(), rand_child(), 12'($urandom));
    else if (r < 77) send_item(bine_pkg::K_SETKEY, rand_key(), rand_child(), 12'($urandom));
    else if (r < 92) send_item(bine_pkg::K_DELETE, rand_key(), rand_child(), 12'($urandom));
    else send_item(bine_pkg::K_LEND, rand_key(), rand_child(), 12'($urandom));
  endtask

  dir_row_t dir_rows[] = '{
    '{bine_pkg::K_INIT,   64'd0,  64'd100, 12'd0,   1, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_LOOKUP, 64'd0,  64'd0,   12'd0,   1, bine_pkg::ST_OK,        64'd100, 8'd0},
    '{bine_pkg::K_INSERT, 64'd50, 64'd200, 12'd0,   1, bine_pkg::ST_OK,        64'd0,   8'd1},
    '{bine_pkg::K_INSERT, '1,     64'd300, 12'd0,   1, bine_pkg::ST_OK,        64'd0,   8'd2},
    '{bine_pkg::K_INSERT, 64'd0,  64'd400, 12'd0,   1, bine_pkg::ST_OK,        64'd0,   8'd3},
    '{bine_pkg::K_LOOKUP, '1,     64'd0,   12'd0,   1, bine_pkg::ST_OK,        64'd300, 8'd3},
    '{bine_pkg::K_LOOKUP, 64'd49, 64'd0,   12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_LEFT,   64'd0,  64'd100, 12'd0,   1, bine_pkg::ST_NO_LEFT,   64'd0,   8'd3},
    '{bine_pkg::K_RIGHT,  64'd0,  64'd300, 12'd0,   1, bine_pkg::ST_NO_RIGHT,  64'd0,   8'd3},
    '{bine_pkg::K_LEFT,   64'd0,  64'd200, 12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_RIGHT,  64'd0,  64'd400, 12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_LEFT,   64'd0,  64'd999, 12'd0,   1, bine_pkg::ST_NOT_FOUND, 64'd0,   8'd3},
    '{bine_pkg::K_SETKEY, 64'd60, 64'd400, 12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_SETKEY, 64'd1,  64'd300, 12'd0,   1, bine_pkg::ST_NO_RIGHT,  64'd0,   8'd3},
    '{bine_pkg::K_SETKEY, 64'd1,  64'd7,   12'd0,   1, bine_pkg::ST_NOT_FOUND, 64'd0,   8'd3},
    '{bine_pkg::K_DELETE, 64'd0,  64'd400, 12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_DELETE, 64'd0,  64'd300, 12'd0,   1, bine_pkg::ST_NO_RIGHT,  64'd0,   8'd2},
    '{bine_pkg::K_DELETE, 64'd0,  64'd5,   12'd0,   1, bine_pkg::ST_NOT_FOUND, 64'd0,   8'd2},
    '{bine_pkg::K_LEND,   64'd0,  64'd0,   12'd0,   0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_LEND,   '1,     '1,      12'hfff, 0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_INSERT, '1,     '1,      12'hfff, 0, bine_pkg::ST_OK,        64'd0,   8'd0},
    '{bine_pkg::K_LOOKUP, '1,     64'd0,   12'd0,   1, bine_pkg::ST_OK,        '1,      8'd3},
    '{bine_pkg::K_INIT,   64'd0,  64'd0,   12'd0,   1, bine_pkg::ST_OK,        64'd0,   8'd0}
  };

  initial begin
    logic [11:0] thr_set[4];
    nd_count = 0;
    nd_thr = bine_pkg::THR_RESET;
    req.valid = 0;
    req.kind = bine_pkg::K_INIT;
    req.key = '0;
    req.child_id = '0;
    req.needed_bytes = '0;
    cfg.valid = 0;
    cfg.data = '0;
    quiet = 0;
    long_hold = 0;
    row_typed = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed part runs at the reset threshold
    foreach (dir_rows[n]) begin
      row_now = dir_rows[n];
      row_typed = dir_rows[n].typed;
      send_item(dir_rows[n].kind, dir_rows[n].key, dir_rows[n].cid, dir_rows[n].need);
      row_typed = 0;
    end

    thr_set = '{12'd0, 12'hfff, 12'd300, 12'($urandom)};
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      quiet = (p == 2);
      for (int n = 0; n < 110; n++) random_item(p == 1 ? 60 : 24);
      // hold the result side off while items keep coming
      long_hold = 400;
      for (int n = 0; n < 6; n++) random_item(24);
    end
    quiet = 0;

    // fill the node to the brim, then hit it when full
    write_threshold(12'd40);
    send_item(bine_pkg::K_INIT, 64'd0, 64'd7, 12'd0);
    for (int n = 0; n < bine_pkg::KEY_SLOTS + 2; n++)
      send_item(bine_pkg::K_INSERT, {$urandom, $urandom}, {$urandom, $urandom},
                12'($urandom));
    for (int n = 0; n < 20; n++) begin
      if (n == 10) write_threshold(12'($urandom));
      send_item(bine_pkg::K_LEND, rand_key(), 64'd0, 12'($urandom));
      random_item(bine_pkg::KEY_SLOTS);
    end
    drain();
    for (int n = 0; n < 40; n++) send_item(bine_pkg::K_DELETE, 64'd0, rand_child(), 12'd0);
    send_item(bine_pkg::K_INIT, 64'd0, 64'd1, 12'd0);

    drain();
    repeat (1100) @(posedge clk);
    $display("%0d items in, %0d results checked; full-node inserts %0d, lends granted %0d",
             beats_in, beats_out, full_hits, lend_yes);
    $display("kinds: init %0d lookup %0d insert %0d left %0d right %0d set %0d del %0d lend %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6], kind_seen[7]);
    if (err_count == 0 && pending_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
